[rtl/core/brl_pkg.sv]
// Package for the line rasterizer: widths, defaults, FSM state type and
// the command/status structs between controller and datapath. No dependencies.
package brl_pkg;

   localparam int COORD_W           = 6;
   localparam int ERR_W             = COORD_W + 2;
   localparam int DEF_PANEL_WIDTH   = 64;
   localparam int DEF_PANEL_HEIGHT  = 64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_WALK
   } brl_state_type;

   typedef struct packed {
      logic load;   // capture the clamped endpoints and color
      logic setup;  // order endpoints, latch spans and the initial error term
      logic step;   // emit one pixel into the output register and advance
   } brl_cmd_type;

   typedef struct packed {
      logic out_free;  // output register is empty or being taken this cycle
      logic at_end;    // current major coordinate is the far endpoint
   } brl_status_type;

endpackage

[rtl/core/brl_ctrl.sv]
// Controller FSM for the line rasterizer.
// Depends on brl_pkg (state enum, command and status structs).
module brl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  brl_pkg::brl_status_type status,
   output brl_pkg::brl_cmd_type    cmd
);

   brl_pkg::brl_state_type state_ff;
   brl_pkg::brl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         brl_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = brl_pkg::ST_SETUP;
            end
         end
         brl_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = brl_pkg::ST_WALK;
         end
         brl_pkg::ST_WALK: begin
            // advance only when the output register can take a pixel
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.at_end) begin
                  state_in = brl_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = brl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/brl_datapath.sv]
// Datapath for the line rasterizer: endpoint clamp, octant setup, error
// stepper and output register. Depends on brl_pkg.
module brl_datapath #(
   parameter int PANEL_WIDTH  = brl_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = brl_pkg::DEF_PANEL_HEIGHT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  brl_pkg::brl_cmd_type         cmd,
   output brl_pkg::brl_status_type      status,
   input  logic [brl_pkg::COORD_W-1:0]  req_x_start,
   input  logic [brl_pkg::COORD_W-1:0]  req_y_start,
   input  logic [brl_pkg::COORD_W-1:0]  req_x_end,
   input  logic [brl_pkg::COORD_W-1:0]  req_y_end,
   input  logic                         req_color,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [brl_pkg::COORD_W-1:0]  rsp_pixel_x,
   output logic [brl_pkg::COORD_W-1:0]  rsp_pixel_y,
   output logic                         rsp_pixel_color,
   output logic                         rsp_last
);

   localparam int CW = brl_pkg::COORD_W;
   localparam int EW = brl_pkg::ERR_W;
   localparam logic [CW-1:0] X_MAX = CW'(PANEL_WIDTH - 1);
   localparam logic [CW-1:0] Y_MAX = CW'(PANEL_HEIGHT - 1);

   // captured endpoints
   logic [CW-1:0] xa_ff, ya_ff, xb_ff, yb_ff;
   logic          color_ff;

   // walk state
   logic [CW-1:0]        m_ff, mb_ff, n_ff, span_ff, minor_span_ff;
   logic                 dir_up_ff, steep_ff;
   logic signed [EW-1:0] err_ff;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] pixel_x_ff, pixel_y_ff;
   logic          pixel_color_ff, last_ff;

   // setup logic
   logic [CW-1:0] dx, dy, a_maj, a_min, b_maj, b_min;
   logic [CW-1:0] ma, mb, na, nb, span_w;
   logic          steep, swap;

   // step logic
   logic signed [EW-1:0] err_dec, err_next;

   always_comb begin
      dx     = (xb_ff >= xa_ff) ? (xb_ff - xa_ff) : (xa_ff - xb_ff);
      dy     = (yb_ff >= ya_ff) ? (yb_ff - ya_ff) : (ya_ff - yb_ff);
      steep  = dy > dx;
      a_maj  = steep ? ya_ff : xa_ff;
      a_min  = steep ? xa_ff : ya_ff;
      b_maj  = steep ? yb_ff : xb_ff;
      b_min  = steep ? xb_ff : yb_ff;
      swap   = a_maj > b_maj;
      ma     = swap ? b_maj : a_maj;
      mb     = swap ? a_maj : b_maj;
      na     = swap ? b_min : a_min;
      nb     = swap ? a_min : b_min;
      span_w = mb - ma;
   end

   always_comb begin
      err_dec  = err_ff - $signed({2'b00, minor_span_ff});
      err_next = err_dec;
      if (err_dec < 0) begin
         err_next = err_dec + $signed({2'b00, span_ff});
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.at_end   = (m_ff == mb_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         // saturate coordinates that lie beyond the panel
         xa_ff    <= (req_x_start > X_MAX) ? X_MAX : req_x_start;
         ya_ff    <= (req_y_start > Y_MAX) ? Y_MAX : req_y_start;
         xb_ff    <= (req_x_end   > X_MAX) ? X_MAX : req_x_end;
         yb_ff    <= (req_y_end   > Y_MAX) ? Y_MAX : req_y_end;
         color_ff <= req_color;
      end
      if (cmd.setup) begin
         steep_ff      <= steep;
         m_ff          <= ma;
         mb_ff         <= mb;
         n_ff          <= na;
         dir_up_ff     <= na < nb;
         span_ff       <= span_w;
         minor_span_ff <= steep ? dx : dy;
         // start the error term at half the major span, rounded down
         err_ff        <= $signed({2'b00, 1'b0, span_w[CW-1:1]});
      end
      if (cmd.step) begin
         pixel_x_ff     <= steep_ff ? n_ff : m_ff;
         pixel_y_ff     <= steep_ff ? m_ff : n_ff;
         pixel_color_ff <= color_ff;
         last_ff        <= (m_ff == mb_ff);
         m_ff           <= m_ff + 1'b1;
         err_ff         <= err_next;
         if (err_dec < 0) begin
            n_ff <= dir_up_ff ? (n_ff + 1'b1) : (n_ff - 1'b1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.step) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = pixel_x_ff;
   assign rsp_pixel_y     = pixel_y_ff;
   assign rsp_pixel_color = pixel_color_ff;
   assign rsp_last        = last_ff;

endmodule

[rtl/core/bresenham_line_rasterizer.sv]
// Top level of the line rasterizer: joins the controller FSM and datapath.
// Depends on brl_pkg, brl_ctrl and brl_datapath.
//
// Usage: the req_ channel carries one line command (two endpoints and a color),
//   taken at a rising edge with req_valid high and req_stall low. The rsp_
//   channel returns the line's pixels in order of rising major coordinate, one
//   item per pixel; rsp_last marks the final pixel. Endpoints beyond the panel
//   saturate to its last column or row.
// Timing: acceptance captures the endpoints and enters a setup state that
//   latches the spans; the first walk step then loads the output register and
//   raises rsp_valid. Pixels then come one per cycle while rsp_stall is low,
//   set by the single error stepper in the datapath. A line has N pixels
//   (N = major span + 1, at most 64); req_stall stays high from acceptance
//   until the last pixel has entered the output register, so the next command
//   may be taken while that last pixel still waits for the receiver.
//   When rsp_stall is high the output register holds its pixel and the walk
//   pauses without losing state.
// Reset: synchronous, active high. Returns the FSM to idle and drops
//   rsp_valid; a line in progress is discarded.
module bresenham_line_rasterizer #(
   parameter int PANEL_WIDTH  = brl_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = brl_pkg::DEF_PANEL_HEIGHT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [brl_pkg::COORD_W-1:0]  req_x_start,
   input  logic [brl_pkg::COORD_W-1:0]  req_y_start,
   input  logic [brl_pkg::COORD_W-1:0]  req_x_end,
   input  logic [brl_pkg::COORD_W-1:0]  req_y_end,
   input  logic                         req_color,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [brl_pkg::COORD_W-1:0]  rsp_pixel_x,
   output logic [brl_pkg::COORD_W-1:0]  rsp_pixel_y,
   output logic                         rsp_pixel_color,
   output logic                         rsp_last
);

   // controller to datapath commands, datapath to controller status
   brl_pkg::brl_cmd_type    cmd;
   brl_pkg::brl_status_type status;

   brl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   brl_datapath #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_color       (req_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

endmodule

[rtl/core/brl_checker.sv]
// Port-level checker for the line rasterizer, bound to the top level.
// Depends on brl_pkg and bresenham_line_rasterizer.
module brl_checker #(
   parameter int PANEL_WIDTH  = brl_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = brl_pkg::DEF_PANEL_HEIGHT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [brl_pkg::COORD_W-1:0]  rsp_pixel_x,
   input logic [brl_pkg::COORD_W-1:0]  rsp_pixel_y,
   input logic                         rsp_pixel_color,
   input logic                         rsp_last
);

   localparam logic [brl_pkg::COORD_W-1:0] X_MAX = brl_pkg::COORD_W'(PANEL_WIDTH - 1);
   localparam logic [brl_pkg::COORD_W-1:0] Y_MAX = brl_pkg::COORD_W'(PANEL_HEIGHT - 1);

   // hold a stalled pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_pixel_color) && $stable(rsp_last))
      else $error("stalled pixel changed or dropped");

   // drop the output after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // no new command while a line is still being emitted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("command accepted mid-line");

   // a taken command blocks the next one during setup
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("back-to-back command acceptance");

   // every pixel lies on the panel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_x <= X_MAX && rsp_pixel_y <= Y_MAX)
      else $error("pixel off the panel");

endmodule

bind bresenham_line_rasterizer brl_checker #(
   .PANEL_WIDTH  (PANEL_WIDTH),
   .PANEL_HEIGHT (PANEL_HEIGHT)
) u_brl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_pixel_color (rsp_pixel_color),
   .rsp_last        (rsp_last)
);

[tb/brl_line_checker.sv]
// Checker for the line rasterizer: watches the req_ and rsp_ channels, predicts
// each line's pixels and compares them in order. Depends on brl_pkg.
module brl_line_checker #(
   parameter int PANEL_WIDTH  = brl_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = brl_pkg::DEF_PANEL_HEIGHT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [brl_pkg::COORD_W-1:0] req_x_start,
   input  logic [brl_pkg::COORD_W-1:0] req_y_start,
   input  logic [brl_pkg::COORD_W-1:0] req_x_end,
   input  logic [brl_pkg::COORD_W-1:0] req_y_end,
   input  logic                        req_color,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [brl_pkg::COORD_W-1:0] rsp_pixel_x,
   input  logic [brl_pkg::COORD_W-1:0] rsp_pixel_y,
   input  logic                        rsp_pixel_color,
   input  logic                        rsp_last,
   output int                          mismatches,
   output int                          pending,
   output int                          pixels_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [brl_pkg::COORD_W-1:0] x;
      logic [brl_pkg::COORD_W-1:0] y;
      logic                        color;
      logic                        last;
   } pixel_type;

   pixel_type pixel_q[$];

   function automatic int saturate(input int v, input int limit);
      return (v > limit - 1) ? limit - 1 : v;
   endfunction

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // Walk the line along its major axis and queue one pixel per step.
   function automatic void queue_line_pixels(input int xs, input int ys, input int xe,
                                             input int ye, input logic color);
      int        xa, ya, xb, yb;
      int        maj_a, min_a, maj_b, min_b;
      int        span, minor_span, err, minor, minor_dir, k;
      bit        steep;
      pixel_type px;
      xa = saturate(xs, PANEL_WIDTH);
      ya = saturate(ys, PANEL_HEIGHT);
      xb = saturate(xe, PANEL_WIDTH);
      yb = saturate(ye, PANEL_HEIGHT);
      steep = magnitude(yb - ya) > magnitude(xb - xa);
      if (steep) begin
         maj_a = ya; min_a = xa; maj_b = yb; min_b = xb;
      end else begin
         maj_a = xa; min_a = ya; maj_b = xb; min_b = yb;
      end
      if (maj_a > maj_b) begin
         {maj_a, maj_b} = {maj_b, maj_a};
         {min_a, min_b} = {min_b, min_a};
      end
      span       = maj_b - maj_a;
      minor_span = magnitude(min_b - min_a);
      err        = span / 2;
      minor_dir  = (min_a < min_b) ? 1 : -1;
      minor      = min_a;
      for (k = 0; k <= span; k++) begin
         px.x     = brl_pkg::COORD_W'(steep ? minor : maj_a + k);
         px.y     = brl_pkg::COORD_W'(steep ? maj_a + k : minor);
         px.color = color;
         px.last  = (k == span);
         pixel_q.push_back(px);
         err -= minor_span;
         if (err < 0) begin
            minor += minor_dir;
            err   += span;
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t brl_line_checker: %s: got %0d, want %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Pixels of a line show up only after its command has passed setup, so
   // retire the result before queueing a command taken at the same edge.
   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         pixel_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pixel_q.size() == 0) begin
               report_mismatch("pixel with no line pending, x", rsp_pixel_x, -1);
            end else begin
               want = pixel_q.pop_front();
               if (rsp_pixel_x !== want.x)
                  report_mismatch("pixel_x", rsp_pixel_x, want.x);
               if (rsp_pixel_y !== want.y)
                  report_mismatch("pixel_y", rsp_pixel_y, want.y);
               if (rsp_pixel_color !== want.color)
                  report_mismatch("pixel_color", rsp_pixel_color, want.color);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
               pixels_checked++;
            end
         end
         if (req_valid && !req_stall)
            queue_line_pixels(req_x_start, req_y_start, req_x_end, req_y_end, req_color);
      end
      pending = pixel_q.size();
   end

endmodule

[tb/tb_bresenham_line_rasterizer.sv]
// Testbench top for the line rasterizer: drives line commands and receiver
// stalls, and gives the verdict. Depends on brl_pkg, the block and brl_line_checker.
module tb_bresenham_line_rasterizer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINES_PER_MIX = 88;       // four idle/stall mixes, about 350 lines
   localparam int HOLD_CYCLES   = 200;      // long receiver hold-off
   localparam int DRAIN_CYCLES  = 8;        // extra edges after the final drain
   localparam int CYCLE_LIMIT   = 1000000;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [brl_pkg::COORD_W-1:0] req_x_start;
   logic [brl_pkg::COORD_W-1:0] req_y_start;
   logic [brl_pkg::COORD_W-1:0] req_x_end;
   logic [brl_pkg::COORD_W-1:0] req_y_end;
   logic                        req_color;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [brl_pkg::COORD_W-1:0] rsp_pixel_x;
   logic [brl_pkg::COORD_W-1:0] rsp_pixel_y;
   logic                        rsp_pixel_color;
   logic                        rsp_last;

   int mismatches;
   int pending;
   int pixels_checked;

   int   idle_pct;              // sender gap chance, used by the stimulus process only
   int   stall_pct = 0;         // receiver stall chance, written with nonblocking updates
   logic hold_toggle = 1'b0;    // flip to ask the receiver for a long hold-off
   int   lines_sent = 0;
   int   cycle_count = 0;

   bresenham_line_rasterizer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_color       (req_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

   brl_line_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_color       (req_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last),
      .mismatches      (mismatches),
      .pending         (pending),
      .pixels_checked  (pixels_checked)
   );

   always #6 clock = ~clock;

   // Guard against a hung block: end the run once the cycle budget is spent.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_bresenham_line_rasterizer: done, errors");
         $finish;
      end
   end

   // Receiver: stall at random per stall_pct. On a flip of hold_toggle, hold
   // stall high through a long hold-off so the block backs up into req_stall.
   initial begin : receiver
      logic hold_seen;
      hold_seen = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Offer one line command and return at the edge that accepts it. Gaps are
   // decided before valid rises, so valid never follows stall. req_stall only
   // moves with edges, so sample it at the falling edge to stay race free.
   task automatic offer_line(input int xs, input int ys, input int xe, input int ye,
                             input logic color);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_start <= brl_pkg::COORD_W'(xs);
      req_y_start <= brl_pkg::COORD_W'(ys);
      req_x_end   <= brl_pkg::COORD_W'(xe);
      req_y_end   <= brl_pkg::COORD_W'(ye);
      req_color   <= color;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      lines_sent++;
   endtask

   // Drop valid and hold the sender until the checker has no pixel left to see.
   task automatic drain_lines();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   // Build a random line: mostly arbitrary endpoints, then short lines,
   // axis-aligned and diagonal ones, and single points.
   task automatic offer_random_line();
      int xs, ys, xe, ye, kind, d;
      xs   = $urandom_range(0, 63);
      ys   = $urandom_range(0, 63);
      xe   = $urandom_range(0, 63);
      ye   = $urandom_range(0, 63);
      kind = $urandom_range(0, 9);
      if (kind inside {6, 7}) begin
         xe = xs + $urandom_range(0, 8) - 4;
         ye = ys + $urandom_range(0, 8) - 4;
         xe = (xe < 0) ? 0 : (xe > 63) ? 63 : xe;
         ye = (ye < 0) ? 0 : (ye > 63) ? 63 : ye;
      end else if (kind == 8) begin
         case ($urandom_range(0, 2))
            0: ye = ys;
            1: xe = xs;
            default: begin
               d  = $urandom_range(0, 63 - ((xs > ys) ? xs : ys));
               xe = xs + d;
               ye = ys + d;
               if ($urandom_range(0, 1)) begin
                  xs = 63 - xs;
                  xe = 63 - xe;
               end
            end
         endcase
      end else if (kind == 9) begin
         xe = xs;
         ye = ys;
      end
      offer_line(xs, ys, xe, ye, 1'($urandom_range(0, 1)));
   endtask

   initial begin : stimulus
      int idle_mix[4];
      int stall_mix[4];
      int m, n;
      idle_mix    = '{0, 58, 0, 30};
      stall_mix   = '{0, 0, 58, 30};
      idle_pct    = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_x_start = '0;
      req_y_start = '0;
      req_x_end   = '0;
      req_y_end   = '0;
      req_color   = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed lines, no idling: single points at both corners, full-panel
      // horizontals and verticals both ways, equal spans (walked along columns),
      // shallow and steep lines with falling minor coordinate, reversed ends.
      offer_line( 0,  0,  0,  0, 1'b1);
      offer_line(63, 63, 63, 63, 1'b0);
      offer_line( 0,  0, 63,  0, 1'b1);
      offer_line(63, 63,  0, 63, 1'b0);
      offer_line( 0,  0,  0, 63, 1'b1);
      offer_line(63, 63, 63,  0, 1'b0);
      offer_line( 0,  0, 63, 63, 1'b1);
      offer_line(63,  0,  0, 63, 1'b0);
      offer_line( 0, 63, 63,  0, 1'b1);
      offer_line(63, 63,  0,  0, 1'b0);
      offer_line( 0,  0, 63,  1, 1'b1);
      offer_line( 0,  0,  1, 63, 1'b0);
      offer_line(10, 40, 50, 20, 1'b1);
      offer_line(50, 20, 10, 40, 1'b0);
      offer_line(20, 10, 35, 60, 1'b1);
      offer_line(35, 60, 20, 10, 1'b0);
      offer_line(40,  5, 30, 55, 1'b1);
      offer_line( 5,  5,  9,  9, 1'b0);
      offer_line( 9,  5,  5,  9, 1'b1);
      offer_line(30, 30, 31, 30, 1'b0);
      offer_line(30, 30, 30, 31, 1'b1);
      offer_line(30, 30, 31, 32, 1'b0);
      drain_lines();

      // Long receiver hold-off while the sender keeps offering: the block
      // fills its output register and stalls req_ until the hold lifts.
      hold_toggle <= ~hold_toggle;
      repeat (6) offer_random_line();
      drain_lines();

      // Random lines under each idle/stall mix; drain between mixes.
      for (m = 0; m < 4; m++) begin
         idle_pct  = idle_mix[m];
         stall_pct <= stall_mix[m];
         for (n = 0; n < LINES_PER_MIX; n++)
            offer_random_line();
         drain_lines();
      end

      stall_pct <= 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      $display("tb_bresenham_line_rasterizer: %0d lines, %0d pixels checked", lines_sent,
               pixels_checked);
      $display("tb_bresenham_line_rasterizer: points, axis, diagonal and random lines;");
      $display("   free flow, sender gaps, receiver stalls, both, one long hold-off");
      if (mismatches == 0 && pending == 0) begin
         $display("tb_bresenham_line_rasterizer: done, clean");
      end else begin
         $display("tb_bresenham_line_rasterizer: done, errors");
      end
      $finish;
   end

endmodule
